/* src/itf_pkg.sv */
`timescale 1ns / 1ps
package itf_pkg;

	// Configuration port geometry.
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W = 7;

	// Register indexes.
	localparam logic [CFG_INDEX_W-1:0] REG_CONVERSION      = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_SIZE_QUALIFIER  = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_FORMAT_FLAGS    = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_FIELD_WIDTH     = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_PRECISION       = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_PRECISION_GIVEN = 3'd5;

	// Conversion codes.
	localparam logic [2:0] CONV_SDEC = 3'd0;
	localparam logic [2:0] CONV_UDEC = 3'd1;
	localparam logic [2:0] CONV_LHEX = 3'd2;
	localparam logic [2:0] CONV_UHEX = 3'd3;
	localparam logic [2:0] CONV_OCT  = 3'd4;
	localparam logic [2:0] CONV_BIN  = 3'd5;

	// Size qualifier codes.
	localparam logic [1:0] SIZE_INT   = 2'd0;
	localparam logic [1:0] SIZE_SHORT = 2'd1;
	localparam logic [1:0] SIZE_CHAR  = 2'd2;

	// Bit positions in the flags register.
	localparam int FLAG_SPACE = 0;
	localparam int FLAG_PLUS  = 1;
	localparam int FLAG_MINUS = 2;
	localparam int FLAG_HASH  = 3;
	localparam int FLAG_ZERO  = 4;
	localparam int FLAG_BANG  = 5;
	localparam int FLAG_CARET = 6;

	// Longest text delivered for one value.
	localparam int MAX_OUT = 64;

	// ASCII codes.
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_PLUS  = 8'h2B;
	localparam logic [7:0] CHAR_MINUS = 8'h2D;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_UA    = 8'h41;
	localparam logic [7:0] CHAR_UX    = 8'h58;
	localparam logic [7:0] CHAR_LB    = 8'h62;
	localparam logic [7:0] CASE_BIT   = 8'h20;

	typedef enum logic [1:0] {
		RADIX_DEC,
		RADIX_HEX,
		RADIX_OCT,
		RADIX_BIN
	} radix_t;

	typedef enum logic [2:0] {
		OP_HOLD,
		OP_LOAD_BIN,
		OP_LOAD_WORD,
		OP_DABBLE,
		OP_SHIFT
	} dig_op_t;

	typedef struct packed {
		dig_op_t op;
		radix_t  radix;
	} dig_cmd_t;

	typedef struct packed {
		logic [1:0] pfx_len;
		logic       minus;
		logic       zero;
		logic       caret;
	} pad_ctl_t;

	// Digit value to its character in the table 0123456789ABCDEF, lowercased when lower is set.
	function automatic logic [7:0] digit_char(input logic [3:0] d, input logic lower);
		logic [7:0] c;
		c = (d < 4'd10) ? (CHAR_ZERO + {4'd0, d}) : (CHAR_UA + {4'd0, d} - 8'd10);
		if (lower) begin
			c = c | CASE_BIT;
		end
		return c;
	endfunction

endpackage

/* src/itf_value_if.sv */
`timescale 1ns / 1ps
interface itf_value_if #(
	parameter int VALUE_BITS = 32
);
	logic                  valid;
	logic                  ready;
	logic [VALUE_BITS-1:0] value;

	modport source(output valid, output value, input ready);
	modport sink(input valid, input value, output ready);
endinterface

/* src/itf_char_if.sv */
`timescale 1ns / 1ps
interface itf_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_char;
	logic       last;

	modport source(output valid, output text_char, output last, input ready);
	modport sink(input valid, input text_char, input last, output ready);
endinterface

/* src/itf_digit_unit.sv */
`timescale 1ns / 1ps
module itf_digit_unit
	import itf_pkg::*;
#(
	parameter int VALUE_BITS = 32,
	parameter int DW = 48
) (
	input  logic                  clk,
	input  dig_cmd_t              cmd,
	input  logic [VALUE_BITS-1:0] mag,
	output logic [3:0]            top_digit
);

	localparam int ND = DW / 4;

	logic [DW-1:0]         word_q;
	logic [VALUE_BITS-1:0] bin_q;
	logic [DW-1:0]         adj;
	logic [DW-1:0]         shifted;

	// Add-three correction on every BCD digit before the next shift.
	always_comb begin
		for (int i = 0; i < ND; i++) begin
			adj[4*i +: 4] = (word_q[4*i +: 4] >= 4'd5) ? (word_q[4*i +: 4] + 4'd3)
				: word_q[4*i +: 4];
		end
	end

	always_comb begin
		unique case (cmd.radix)
			RADIX_DEC, RADIX_HEX: begin
				shifted = word_q << 4;
				top_digit = word_q[DW-1 -: 4];
			end
			RADIX_OCT: begin
				shifted = word_q << 3;
				top_digit = {1'b0, word_q[DW-1 -: 3]};
			end
			RADIX_BIN: begin
				shifted = word_q << 1;
				top_digit = {3'd0, word_q[DW-1]};
			end
		endcase
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_LOAD_BIN: begin
				word_q <= '0;
				bin_q <= mag;
			end
			OP_LOAD_WORD: begin
				word_q <= DW'(mag);
			end
			OP_DABBLE: begin
				word_q <= {adj[DW-2:0], bin_q[VALUE_BITS-1]};
				bin_q <= bin_q << 1;
			end
			OP_SHIFT: begin
				word_q <= shifted;
			end
			default: begin
			end
		endcase
	end

endmodule

/* src/itf_layout.sv */
`timescale 1ns / 1ps
module itf_layout
	import itf_pkg::*;
#(
	parameter int CW = 7
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [CW-1:0] ndig,
	input  logic [CW-1:0] prec,
	input  logic [CW-1:0] width,
	input  pad_ctl_t      ctl,
	output logic          done,
	output logic [CW-1:0] b1,
	output logic [CW-1:0] b2,
	output logic [CW-1:0] b3,
	output logic [CW-1:0] b4,
	output logic [CW-1:0] total
);

	localparam logic [CW-1:0] OUT_LIMIT = CW'(MAX_OUT);

	logic          a_q, b_q, c_q, d_q;
	logic [CW-1:0] num_w_q, padw_q;
	logic [CW-1:0] ps1_q, ps2_q, pz_q;
	logic [CW-1:0] b1_q, b2_q, b3_q, b4_q, n_q, total_q;
	logic [CW-1:0] pfx_ext, num_w, length, padw, spc, zpad;

	assign pfx_ext = CW'(ctl.pfx_len);
	assign num_w = (ndig > prec) ? ndig : prec;
	assign length = num_w + pfx_ext;
	assign padw = (length < width) ? (width - length) : '0;

	// Space padding goes before, after or on both sides; zero padding only without minus.
	assign spc = (ctl.minus || !ctl.zero) ? padw_q : '0;
	assign zpad = (!ctl.minus && ctl.zero) ? padw_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q <= 1'b0;
			b_q <= 1'b0;
			c_q <= 1'b0;
			d_q <= 1'b0;
		end else begin
			a_q <= start;
			b_q <= a_q;
			c_q <= b_q;
			d_q <= c_q;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_w_q <= num_w;
			padw_q <= padw;
		end
		if (a_q) begin
			ps1_q <= ctl.caret ? (spc >> 1) : (ctl.minus ? '0 : spc);
			ps2_q <= ctl.caret ? (spc - (spc >> 1)) : (ctl.minus ? spc : '0);
			pz_q <= num_w_q - ndig + zpad;
		end
		if (b_q) begin
			b1_q <= ps1_q;
			b2_q <= ps1_q + pfx_ext;
			b3_q <= ps1_q + pfx_ext + pz_q;
			b4_q <= ps1_q + pfx_ext + pz_q + ndig;
			n_q <= ps1_q + pfx_ext + pz_q + ndig + ps2_q;
		end
		if (c_q) begin
			total_q <= (n_q > OUT_LIMIT) ? OUT_LIMIT : n_q;
		end
	end

	assign done = d_q;
	assign b1 = b1_q;
	assign b2 = b2_q;
	assign b3 = b3_q;
	assign b4 = b4_q;
	assign total = total_q;

endmodule

/* src/integer_to_text_formatter_top.sv */
`timescale 1ns / 1ps
// Printf-style integer formatter. A request on the values channel carries one raw
// value; the block answers with its text on the chars channel, one ASCII character
// per request, with last set on the final character. A value whose text is empty
// produces no character at all.
// The configuration port (cfg_we, cfg_index, cfg_data) sets conversion, size
// qualifier, flags, field width and precision; write it only while the block is idle.
// One value is handled at a time. After acceptance the shared digit unit runs:
// decimal conversions first run double-dabble over the VALUE_BITS input bits,
// then every radix strips leading zero digits at one digit per cycle (up to
// DW/4 digits for decimal and hex, DW/3 for octal, DW for binary; DW is 48 at
// the default width). Layout arithmetic follows, then one character per cycle
// while the receiver takes them. When the receiver stalls, the character stays
// in the output register and the sequencer waits. The next value is accepted as
// soon as the last character is loaded, even if it is not yet taken.
// Reset clears the sequencer and output valid and restores the register defaults
// (precision 1, everything else 0). No memory is cleared.
module integer_to_text_formatter_top
	import itf_pkg::*;
#(
	parameter int VALUE_BITS = 32,
	parameter int MAX_FIELD = 60
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	itf_value_if.sink              values,
	itf_char_if.source             chars
);

	// Decimal digits needed for the largest value, using log10(2) ~ 1233/4096.
	localparam int DEC_DIGITS = (VALUE_BITS * 1233) / 4096 + 1;
	localparam int RAW_W = (4 * DEC_DIGITS > VALUE_BITS + 3) ? 4 * DEC_DIGITS
		: VALUE_BITS + 3;
	// The digit word is a multiple of 12 bits so that every radix aligns at its top.
	localparam int DW = ((RAW_W + 11) / 12) * 12;
	localparam int CW_SPAN = (DW + MAX_FIELD + 4 > MAX_OUT + 1) ? DW + MAX_FIELD + 4
		: MAX_OUT + 1;
	localparam int CW = $clog2(CW_SPAN);
	localparam int DCW = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
	localparam logic [CW-1:0] NS_QUAD = CW'(DW / 4);
	localparam logic [CW-1:0] NS_OCT = CW'(DW / 3);
	localparam logic [CW-1:0] NS_BIN = CW'(DW);
	localparam logic [VALUE_BITS-1:0] ONES = '1;
	localparam logic [VALUE_BITS-1:0] MASK16 = ONES >> ((VALUE_BITS > 16) ? VALUE_BITS - 16 : 0);
	localparam logic [VALUE_BITS-1:0] MASK8 = ONES >> (VALUE_BITS - 8);
	localparam int MSB16 = (VALUE_BITS > 16) ? 15 : VALUE_BITS - 1;
	localparam logic [5:0] FIELD_LIMIT = 6'(MAX_FIELD);

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_DABBLE = 5'b00010,
		S_NORM   = 5'b00100,
		S_LAYOUT = 5'b01000,
		S_EMIT   = 5'b10000
	} state_t;

	// Configuration registers.
	logic [2:0] conversion_q;
	logic [1:0] size_qualifier_q;
	logic [6:0] format_flags_q;
	logic [5:0] field_width_q;
	logic [5:0] precision_q;
	logic       precision_given_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			conversion_q <= CONV_SDEC;
			size_qualifier_q <= SIZE_INT;
			format_flags_q <= '0;
			field_width_q <= '0;
			precision_q <= 6'd1;
			precision_given_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CONVERSION: conversion_q <= cfg_data[2:0];
				REG_SIZE_QUALIFIER: size_qualifier_q <= cfg_data[1:0];
				REG_FORMAT_FLAGS: format_flags_q <= cfg_data[6:0];
				REG_FIELD_WIDTH: field_width_q <= cfg_data[5:0];
				REG_PRECISION: precision_q <= cfg_data[5:0];
				REG_PRECISION_GIVEN: precision_given_q <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	state_t          state_q;
	logic [DCW-1:0]  dab_cnt_q;
	logic [CW-1:0]   slots_q;
	logic [CW-1:0]   pos_q;
	radix_t          radix_q;
	logic            lower_q;
	logic [1:0]      pfx_len_q;
	logic [7:0]      pfx0_q;
	logic [7:0]      pfx1_q;
	logic            out_valid_q;
	logic [7:0]      char_q;
	logic            last_q;

	// Decode of the incoming value, used only in the cycle it is accepted.
	logic [2:0]            conv_eff;
	logic [VALUE_BITS-1:0] mask;
	logic                  msb_bit;
	logic [VALUE_BITS-1:0] raw;
	logic                  neg;
	logic [VALUE_BITS-1:0] mag;
	logic                  mag_nz;
	logic                  has_sign;
	logic [7:0]            sign_char;
	logic [1:0]            pfx_len_in;
	logic [7:0]            pfx0_in;
	logic [7:0]            pfx1_in;
	radix_t                radix_in;
	logic [CW-1:0]         ns_in;
	logic                  accept;

	assign accept = values.valid && values.ready;
	assign values.ready = (state_q == S_IDLE);
	assign conv_eff = (conversion_q > CONV_BIN) ? CONV_UDEC : conversion_q;

	always_comb begin
		unique case (size_qualifier_q)
			SIZE_SHORT: begin
				mask = MASK16;
				msb_bit = values.value[MSB16];
			end
			SIZE_CHAR: begin
				mask = MASK8;
				msb_bit = values.value[7];
			end
			default: begin
				mask = ONES;
				msb_bit = values.value[VALUE_BITS-1];
			end
		endcase
	end

	assign raw = values.value & mask;
	assign neg = (conv_eff == CONV_SDEC) && msb_bit;
	assign mag = neg ? ((~raw + VALUE_BITS'(1)) & mask) : raw;
	assign mag_nz = |mag;

	always_comb begin
		has_sign = 1'b1;
		sign_char = CHAR_SPACE;
		if (neg) begin
			sign_char = CHAR_MINUS;
		end else if (format_flags_q[FLAG_PLUS]) begin
			sign_char = CHAR_PLUS;
		end else if (!format_flags_q[FLAG_SPACE]) begin
			has_sign = 1'b0;
		end
	end

	always_comb begin
		pfx_len_in = 2'd0;
		pfx0_in = CHAR_ZERO;
		pfx1_in = ((conv_eff == CONV_BIN) ? CHAR_LB : CHAR_UX)
			| (((conv_eff == CONV_LHEX) || format_flags_q[FLAG_BANG]) ? CASE_BIT : 8'd0);
		radix_in = RADIX_DEC;
		ns_in = NS_QUAD;
		unique case (conv_eff)
			CONV_SDEC: begin
				if (has_sign) begin
					pfx_len_in = 2'd1;
					pfx0_in = sign_char;
				end
			end
			CONV_OCT: begin
				radix_in = RADIX_OCT;
				ns_in = NS_OCT;
				if (format_flags_q[FLAG_HASH] && mag_nz) begin
					pfx_len_in = 2'd1;
				end
			end
			CONV_LHEX, CONV_UHEX: begin
				radix_in = RADIX_HEX;
				if (format_flags_q[FLAG_HASH] && (format_flags_q[FLAG_BANG] || mag_nz)) begin
					pfx_len_in = 2'd2;
				end
			end
			CONV_BIN: begin
				radix_in = RADIX_BIN;
				ns_in = NS_BIN;
				if (format_flags_q[FLAG_HASH] && (format_flags_q[FLAG_BANG] || mag_nz)) begin
					pfx_len_in = 2'd2;
				end
			end
			default: begin
			end
		endcase
	end

	// Shared digit unit: double-dabble for decimal, then leading-zero stripping
	// and digit popping through the same shifter.
	dig_cmd_t   dig_cmd;
	logic [3:0] top_digit;

	itf_digit_unit #(
		.VALUE_BITS(VALUE_BITS),
		.DW(DW)
	) u_digit (
		.clk(clk),
		.cmd(dig_cmd),
		.mag(mag),
		.top_digit(top_digit)
	);

	// Layout arithmetic: padding split, segment boundaries and total length.
	logic          lay_start;
	logic          lay_done;
	logic [CW-1:0] lay_prec;
	logic [CW-1:0] lay_width;
	pad_ctl_t      lay_ctl;
	logic [CW-1:0] lay_b1, lay_b2, lay_b3, lay_b4, lay_total;

	assign lay_prec = precision_given_q
		? CW'((precision_q > FIELD_LIMIT) ? FIELD_LIMIT : precision_q) : CW'(1);
	assign lay_width = CW'((field_width_q > FIELD_LIMIT) ? FIELD_LIMIT : field_width_q);
	assign lay_ctl.pfx_len = pfx_len_q;
	assign lay_ctl.minus = format_flags_q[FLAG_MINUS];
	// A given precision cancels zero padding.
	assign lay_ctl.zero = format_flags_q[FLAG_ZERO] && !precision_given_q;
	assign lay_ctl.caret = format_flags_q[FLAG_CARET];

	itf_layout #(
		.CW(CW)
	) u_layout (
		.clk(clk),
		.arst_n(arst_n),
		.start(lay_start),
		.ndig(slots_q),
		.prec(lay_prec),
		.width(lay_width),
		.ctl(lay_ctl),
		.done(lay_done),
		.b1(lay_b1),
		.b2(lay_b2),
		.b3(lay_b3),
		.b4(lay_b4),
		.total(lay_total)
	);

	// Character selection by position within the field.
	logic       strip;
	logic       out_free;
	logic       emit;
	logic       is_last;
	logic       in_digits;
	logic [7:0] next_char;

	assign strip = (top_digit == 4'd0) && (slots_q != '0);
	assign lay_start = (state_q == S_NORM) && !strip;
	assign out_free = !out_valid_q || chars.ready;
	assign emit = (state_q == S_EMIT) && (lay_total != '0) && out_free;
	assign is_last = (pos_q == lay_total - CW'(1));
	assign in_digits = (pos_q >= lay_b3) && (pos_q < lay_b4);

	always_comb begin
		priority if (pos_q < lay_b1) begin
			next_char = CHAR_SPACE;
		end else if (pos_q < lay_b2) begin
			next_char = (pos_q == lay_b1) ? pfx0_q : pfx1_q;
		end else if (pos_q < lay_b3) begin
			next_char = CHAR_ZERO;
		end else if (pos_q < lay_b4) begin
			next_char = digit_char(top_digit, lower_q);
		end else begin
			next_char = CHAR_SPACE;
		end
	end

	always_comb begin
		dig_cmd.op = OP_HOLD;
		dig_cmd.radix = radix_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					dig_cmd.radix = radix_in;
					dig_cmd.op = (radix_in == RADIX_DEC) ? OP_LOAD_BIN : OP_LOAD_WORD;
				end
			end
			S_DABBLE: dig_cmd.op = OP_DABBLE;
			S_NORM: begin
				if (strip) begin
					dig_cmd.op = OP_SHIFT;
				end
			end
			S_EMIT: begin
				if (emit && in_digits) begin
					dig_cmd.op = OP_SHIFT;
				end
			end
			default: begin
			end
		endcase
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			dab_cnt_q <= '0;
			slots_q <= '0;
			pos_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						slots_q <= ns_in;
						dab_cnt_q <= DCW'(VALUE_BITS - 1);
						state_q <= (radix_in == RADIX_DEC) ? S_DABBLE : S_NORM;
					end
				end
				S_DABBLE: begin
					if (dab_cnt_q == '0) begin
						state_q <= S_NORM;
					end else begin
						dab_cnt_q <= dab_cnt_q - DCW'(1);
					end
				end
				S_NORM: begin
					if (strip) begin
						slots_q <= slots_q - CW'(1);
					end else begin
						state_q <= S_LAYOUT;
					end
				end
				S_LAYOUT: begin
					if (lay_done) begin
						pos_q <= '0;
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (lay_total == '0) begin
						state_q <= S_IDLE;
					end else if (emit) begin
						pos_q <= pos_q + CW'(1);
						if (is_last) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Per-value prefix and radix, captured at acceptance.
	always_ff @(posedge clk) begin
		if (accept) begin
			radix_q <= radix_in;
			lower_q <= (conv_eff == CONV_LHEX);
			pfx_len_q <= pfx_len_in;
			pfx0_q <= pfx0_in;
			pfx1_q <= pfx1_in;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (chars.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			char_q <= next_char;
			last_q <= is_last;
		end
	end

	assign chars.valid = out_valid_q;
	assign chars.text_char = char_q;
	assign chars.last = last_q;

	// Leading-zero stripping must stop on a nonzero digit or with no digits left.
	assert property (@(posedge clk) disable iff (!arst_n)
		lay_start |-> (slots_q == '0) || (top_digit != 4'd0))
		else $error("layout started on a leading zero digit");

	// Every decimal digit leaving the double-dabble word is a valid BCD digit.
	assert property (@(posedge clk) disable iff (!arst_n)
		emit && in_digits && (radix_q == RADIX_DEC) |-> top_digit < 4'd10)
		else $error("invalid BCD digit emitted");

	// Segment boundaries are ordered and the text fits the output limit.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT) |-> (lay_total <= CW'(MAX_OUT)) && (lay_b1 <= lay_b2)
			&& (lay_b2 <= lay_b3) && (lay_b3 <= lay_b4))
		else $error("inconsistent field layout");

	// The final character is presented with last and frees the sequencer.
	assert property (@(posedge clk) disable iff (!arst_n)
		emit && is_last |=> (state_q == S_IDLE) && chars.valid && chars.last)
		else $error("last character not marked or sequencer still busy");

endmodule
